// ===== design/lca_pkg.sv =====
// lca_pkg: shared constants, item types and address helper for the lca engine
// used by lowest_common_ancestor_binary_lifting; no dependencies
`default_nettype none

package lca_pkg;

  // table geometry
  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 11;

  // field widths
  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int DEPTH_W = 11;
  localparam int COUNT_W = 11;
  localparam int OP_W    = 2;
  localparam int LVL_W   = $clog2(LEVELS);

  // memory geometry
  localparam int ANC_DEPTH = LEVELS * MAX_NODES;
  localparam int ANC_AW    = $clog2(ANC_DEPTH);

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_NODE  = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [NODE_W-1:0]  node_a;
    logic [NODE_W-1:0]  node_b;
    logic [DEPTH_W-1:0] node_depth;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              error;
  } out_item_t;

  // flat address of one ancestor table entry
  function automatic logic [ANC_AW-1:0] anc_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] node);
    anc_addr = ANC_AW'(lvl) * ANC_AW'(MAX_NODES) + ANC_AW'(node);
  endfunction

endpackage

`default_nettype wire

// ===== design/lca_ram.sv =====
// lca_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read data registered; a read of an address being written returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/lowest_common_ancestor_binary_lifting.sv =====
// lowest_common_ancestor_binary_lifting: lca engine over a binary lifting ancestor table
// load is written from idle; build runs BRD1, BRD2, BWR per node in use and level;
// an erroring query goes straight to the result; other queries read depths (QDB, QDC),
// lift the deeper node (LIFT, LWAIT), then descend (DY, DC) and finish (FIN) unless the
// lifted node meets the other; one item at a time, a stalled result holds the next
// reset: synchronous, clears control state and the built flag; memories are not cleared
`default_nettype none

module lowest_common_ancestor_binary_lifting
  import lca_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_BRD1, S_BRD2, S_BWR, S_QDB, S_QDC, S_LIFT, S_LWAIT, S_LDONE,
    S_DY, S_DC, S_FIN, S_RESULT
  } state_t;

  localparam logic [LVL_W-1:0] LAST_LVL  = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] BUILD_END = LVL_W'(LEVELS - 2);

  state_t               state;
  logic [COUNT_W-1:0]   node_count;
  logic [NODE_W-1:0]    root_node;
  logic                 built;
  logic [LVL_W-1:0]     bk;
  logic [NODE_W-1:0]    bv;
  logic [LVL_W-1:0]     k;
  logic [NODE_W-1:0]    x;
  logic [NODE_W-1:0]    y;
  logic [NODE_W-1:0]    px;
  logic [DEPTH_W-1:0]   da;
  logic [LEVELS-1:0]    diff;
  out_item_t            res;

  logic [COUNT_W-1:0]   n_use;
  logic                 a_ok;
  logic                 b_ok;
  logic                 load_fire;
  logic [NODE_W-1:0]    load_par;
  logic [NODE_W-1:0]    desc_nx;
  logic [NODE_W-1:0]    desc_ny;
  logic [LVL_W-1:0]     rd_lvl;
  logic [NODE_W-1:0]    rd_node;

  logic                 anc_we;
  logic [ANC_AW-1:0]    anc_waddr;
  logic [NODE_W-1:0]    anc_wdata;
  logic [ANC_AW-1:0]    anc_raddr;
  logic [NODE_W-1:0]    anc_rdata;
  logic [NODE_W-1:0]    dep_raddr;
  logic [DEPTH_W-1:0]   dep_rdata;

  // nodes in use and range checks on the incoming item
  assign n_use = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;
  assign a_ok  = COUNT_W'(in_data.node_a) < n_use;
  assign b_ok  = COUNT_W'(in_data.node_b) < n_use;

  assign in_stall  = (state != S_IDLE);
  assign load_fire = in_valid && (state == S_IDLE) && (in_data.opcode == OP_LOAD) && a_ok;

  // root is its own parent, out-of-range parents fall back to the root
  assign load_par = (in_data.node_a == root_node) ? in_data.node_a :
                    (b_ok ? in_data.node_b : root_node);

  // descent step: move both nodes up where their ancestors differ
  assign desc_nx = (px != anc_rdata) ? px : x;
  assign desc_ny = (px != anc_rdata) ? anc_rdata : y;

  // ancestor table read address
  always_comb begin
    rd_lvl  = '0;
    rd_node = '0;
    unique case (state)
      S_BRD1: begin
        rd_lvl  = bk;
        rd_node = bv;
      end
      S_BRD2: begin
        rd_lvl  = bk;
        rd_node = anc_rdata;
      end
      S_LIFT: begin
        rd_lvl  = k;
        rd_node = x;
      end
      S_LDONE: begin
        rd_lvl  = LAST_LVL;
        rd_node = x;
      end
      S_DY: begin
        rd_lvl  = k;
        rd_node = y;
      end
      S_DC: begin
        rd_lvl  = (k == '0) ? '0 : k - LVL_W'(1);
        rd_node = desc_nx;
      end
      default: begin
      end
    endcase
  end

  assign anc_raddr = anc_addr(rd_lvl, rd_node);

  // ancestor table write: level zero on load, higher levels during build
  assign anc_we    = load_fire || (state == S_BWR);
  assign anc_waddr = (state == S_BWR) ? anc_addr(bk + LVL_W'(1), bv)
                                      : anc_addr('0, in_data.node_a);
  assign anc_wdata = (state == S_BWR) ? anc_rdata : load_par;

  assign dep_raddr = (state == S_IDLE) ? in_data.node_a : y;

  lca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (ANC_DEPTH)
  ) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  lca_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_NODES)
  ) u_depth_ram (
    .clk   (clk),
    .we    (load_fire),
    .waddr (in_data.node_a),
    .wdata (in_data.node_depth),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= COUNT_W'(1);
      root_node  <= '0;
      built      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NODE_COUNT: node_count <= cfg_data;
          CFG_ROOT_NODE:  root_node  <= cfg_data[NODE_W-1:0];
          default: begin
          end
        endcase
      end

      // result handoff
      if (state == S_RESULT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_data.opcode)
              OP_LOAD: begin
                if (a_ok) begin
                  built <= 1'b0;
                end
              end
              OP_BUILD: begin
                bk <= '0;
                bv <= '0;
                if (n_use == '0) begin
                  built <= 1'b1;
                end else begin
                  state <= S_BRD1;
                end
              end
              OP_QUERY: begin
                x <= in_data.node_a;
                y <= in_data.node_b;
                if (!built || !a_ok || !b_ok) begin
                  res   <= '{ancestor: '0, error: 1'b1};
                  state <= S_RESULT;
                end else begin
                  state <= S_QDB;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_BRD1: state <= S_BRD2;
        S_BRD2: state <= S_BWR;
        S_BWR: begin
          if (COUNT_W'(bv) == n_use - COUNT_W'(1)) begin
            bv <= '0;
            if (bk == BUILD_END) begin
              built <= 1'b1;
              state <= S_IDLE;
            end else begin
              bk    <= bk + LVL_W'(1);
              state <= S_BRD1;
            end
          end else begin
            bv    <= bv + NODE_W'(1);
            state <= S_BRD1;
          end
        end
        S_QDB: begin
          da    <= dep_rdata;
          state <= S_QDC;
        end
        S_QDC: begin
          // deeper node goes to x
          if (da < dep_rdata) begin
            x    <= y;
            y    <= x;
            diff <= LEVELS'(dep_rdata - da);
          end else begin
            diff <= LEVELS'(da - dep_rdata);
          end
          k     <= '0;
          state <= S_LIFT;
        end
        S_LIFT: begin
          if (diff[k]) begin
            state <= S_LWAIT;
          end else if (k == LAST_LVL) begin
            state <= S_LDONE;
          end else begin
            k <= k + LVL_W'(1);
          end
        end
        S_LWAIT: begin
          x <= anc_rdata;
          if (k == LAST_LVL) begin
            state <= S_LDONE;
          end else begin
            k     <= k + LVL_W'(1);
            state <= S_LIFT;
          end
        end
        S_LDONE: begin
          if (x == y) begin
            res   <= '{ancestor: x, error: 1'b0};
            state <= S_RESULT;
          end else begin
            k     <= LAST_LVL;
            state <= S_DY;
          end
        end
        S_DY: begin
          px    <= anc_rdata;
          state <= S_DC;
        end
        S_DC: begin
          x <= desc_nx;
          y <= desc_ny;
          if (k == '0) begin
            state <= S_FIN;
          end else begin
            k     <= k - LVL_W'(1);
            state <= S_DY;
          end
        end
        S_FIN: begin
          res   <= '{ancestor: anc_rdata, error: 1'b0};
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a good answer only comes from a built table
  a_result_built: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT && !res.error) |-> built)
    else $error("non-error result without a built table");

  // the built flag drops only on an accepted in-range load
  a_built_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(built) |-> $past(load_fire))
    else $error("built flag cleared without a load");

  // build writes stay inside the nodes in use
  a_build_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_BWR) |-> (COUNT_W'(bv) < n_use))
    else $error("build write beyond node count");

  // a result is presented only after the sequencer finished a query
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESULT))
    else $error("result presented outside result state");

endmodule

`default_nettype wire

// ===== dv/tb_lowest_common_ancestor_binary_lifting.sv =====
// tb_lowest_common_ancestor_binary_lifting: self-checking bench for the binary lifting lca engine
// predicts every query answer from loads, builds and register writes; depends on lca_pkg and
// lowest_common_ancestor_binary_lifting
`timescale 1ns / 100ps
`default_nettype none

module tb_lowest_common_ancestor_binary_lifting;
  import lca_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int IDLE_PCT = 24;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COUNT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  lowest_common_ancestor_binary_lifting u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow copy of the engine state
  logic [NODE_W-1:0] lift_tab [LEVELS][MAX_NODES];
  logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
  bit tree_ready;
  logic [COUNT_W-1:0] cfg_count;
  logic [NODE_W-1:0] cfg_root;

  out_item_t lca_expect_q[$];
  bit quiet = 1'b0;
  bit table_busy = 1'b0;
  int mismatch_count = 0;
  int loads_sent = 0;
  int builds_sent = 0;
  int queries_sent = 0;
  int answers_checked = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("[lowest_common_ancestor_binary_lifting] ERROR");
      $finish;
    end
  end

  // random backpressure on results
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // compare each accepted answer with the oldest prediction
  always @(posedge clk) begin : check_answers
    out_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      answers_checked++;
      if (lca_expect_q.size() == 0) begin
        $display("%0t: answer with none expected: ancestor %0d error %0b",
                 $time, out_data.ancestor, out_data.error);
        mismatch_count++;
      end else begin
        want = lca_expect_q.pop_front();
        table_busy = 1'b0;
        if (out_data.ancestor !== want.ancestor) begin
          $display("%0t: ancestor mismatch: expected %0d, actual %0d",
                   $time, want.ancestor, out_data.ancestor);
          mismatch_count++;
        end
        if (out_data.error !== want.error) begin
          $display("%0t: error flag mismatch: expected %0b, actual %0b",
                   $time, want.error, out_data.error);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int live_nodes();
    return (cfg_count < MAX_NODES) ? int'(cfg_count) : MAX_NODES;
  endfunction

  // lift the deeper node to equal depth, then both from the top level down
  function automatic logic [NODE_W-1:0] find_lca(input logic [NODE_W-1:0] a_in,
                                                 input logic [NODE_W-1:0] b_in);
    logic [NODE_W-1:0] x, y, px, py;
    logic [DEPTH_W-1:0] gap;
    x = a_in;
    y = b_in;
    if (depth_mem[a_in] < depth_mem[b_in]) begin
      x = b_in;
      y = a_in;
    end
    gap = depth_mem[x] - depth_mem[y];
    for (int k = 0; k < LEVELS; k++) begin
      if (gap[k]) x = lift_tab[k][x];
    end
    if (x == y) return x;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      px = lift_tab[k][x];
      py = lift_tab[k][y];
      if (px != py) begin
        x = px;
        y = py;
      end
    end
    return lift_tab[0][x];
  endfunction

  // update the shadow state for one accepted item and queue its answer
  task automatic predict_item(input in_item_t it);
    int n;
    out_item_t res;
    n = live_nodes();
    case (it.opcode)
      OP_LOAD: begin
        loads_sent++;
        if (it.node_a < n) begin
          if (it.node_a == cfg_root) lift_tab[0][it.node_a] = it.node_a;
          else if (it.node_b < n) lift_tab[0][it.node_a] = it.node_b;
          else lift_tab[0][it.node_a] = cfg_root;
          depth_mem[it.node_a] = it.node_depth;
          tree_ready = 1'b0;
        end
      end
      OP_BUILD: begin
        builds_sent++;
        table_busy = 1'b1;
        for (int k = 0; k + 1 < LEVELS; k++) begin
          for (int v = 0; v < n; v++) lift_tab[k+1][v] = lift_tab[k][lift_tab[k][v]];
        end
        tree_ready = 1'b1;
      end
      OP_QUERY: begin
        queries_sent++;
        if (!tree_ready || it.node_a >= n || it.node_b >= n) begin
          res.ancestor = '0;
          res.error = 1'b1;
        end else begin
          res.ancestor = find_lca(it.node_a, it.node_b);
          res.error = 1'b0;
        end
        lca_expect_q.insert(lca_expect_q.size(), res);
      end
      default: ;
    endcase
  endtask

  // offer one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_item(input logic [OP_W-1:0] op, input int a, input int b, input int d);
    in_item_t it;
    it.opcode = op;
    it.node_a = a[NODE_W-1:0];
    it.node_b = b[NODE_W-1:0];
    it.node_depth = d[DEPTH_W-1:0];
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_item(it);
  endtask

  // stop sending and wait for every pending answer
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lca_expect_q.size() != 0) @(posedge clk);
  endtask

  // give a build with no answer after it time to finish
  task automatic settle();
    repeat (table_busy ? 3 * (LEVELS - 1) * live_nodes() + 64 : 64) @(posedge clk);
    table_busy = 1'b0;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    drain_results();
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[COUNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NODE_COUNT: cfg_count = val[COUNT_W-1:0];
      CFG_ROOT_NODE:  cfg_root = val[NODE_W-1:0];
      default: ;
    endcase
  endtask

  // load a random tree over nodes 0..cnt-1 hanging from the current root
  task automatic load_tree(input int cnt, input bit scrambled);
    int order [MAX_NODES];
    int par [MAX_NODES];
    int dep [MAX_NODES];
    int j, tmp, lo, v, b;
    for (int i = 0; i < cnt; i++) order[i] = i;
    order[cfg_root] = 0;
    order[0] = cfg_root;
    for (int i = cnt - 1; i > 1; i--) begin
      j = $urandom_range(1, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    par[order[0]] = $urandom_range(0, MAX_NODES - 1);
    dep[order[0]] = scrambled ? $urandom_range(1, 2047) : 1;
    // half the nodes hang near the newest ones for deep paths
    for (int i = 1; i < cnt; i++) begin
      lo = ($urandom_range(0, 1) && i > 3) ? i - 3 : 0;
      par[order[i]] = order[$urandom_range(lo, i - 1)];
      dep[order[i]] = scrambled ? $urandom_range(1, 2047) : dep[par[order[i]]] + 1;
    end
    for (int i = cnt - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < cnt; i++) begin
      v = order[i];
      b = par[v];
      // a parent past the node count lands on the root
      if (v != cfg_root && b == cfg_root && cnt < MAX_NODES && $urandom_range(0, 3) == 0)
        b = $urandom_range(cnt, MAX_NODES - 1);
      send_item(OP_LOAD, v, b, dep[v]);
      if (cnt < MAX_NODES && $urandom_range(0, 15) == 0)
        send_item(OP_LOAD, $urandom_range(cnt, MAX_NODES - 1), $urandom_range(0, 1023),
                  $urandom_range(1, 2047));
      if ($urandom_range(0, 31) == 0)
        send_item(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 2047));
    end
  endtask

  // random query pairs over nodes 0..span-1 with reloads, stray opcodes and full pauses
  task automatic ask_queries(input int cnt, input int span);
    int n, a, b, v;
    n = span;
    for (int i = 0; i < cnt; i++) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if ($urandom_range(0, 9) == 0) b = a;
      if (live_nodes() < MAX_NODES && $urandom_range(0, 11) == 0) begin
        if ($urandom_range(0, 1)) a = $urandom_range(live_nodes(), MAX_NODES - 1);
        else b = $urandom_range(live_nodes(), MAX_NODES - 1);
      end
      send_item(OP_QUERY, a, b, $urandom_range(0, 2047));
      if ($urandom_range(0, 39) == 0)
        send_item(OP_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 2047));
      // reload one node: the stale table must answer error until rebuilt
      if (live_nodes() < 512 && $urandom_range(0, 59) == 0) begin
        v = $urandom_range(0, n - 1);
        send_item(OP_LOAD, v, $urandom_range(0, n - 1), $urandom_range(1, 2047));
        send_item(OP_QUERY, a, b, 0);
        send_item(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
      end
      if ($urandom_range(0, 79) == 0) drain_results();
    end
  endtask

  task automatic tree_phase(input int cnt, input int root, input bit scrambled, input int nq);
    set_reg(CFG_NODE_COUNT, cnt);
    set_reg(CFG_ROOT_NODE, root);
    load_tree(live_nodes(), scrambled);
    if ($urandom_range(0, 1)) send_item(OP_QUERY, 0, root, 0);
    send_item(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 2047));
    ask_queries(nq, live_nodes());
  endtask

  // queries before any build, stray opcode, load past the node count
  task automatic test_reset_state();
    send_item(OP_QUERY, 0, 0, 1);
    send_item(OP_UNUSED, 1023, 1023, 2047);
    send_item(OP_LOAD, 5, 0, 1);
    send_item(OP_QUERY, 0, 0, 0);
  endtask

  // default single node tree, root load ignores its parent field
  task automatic test_single_node();
    send_item(OP_LOAD, 0, 1023, 1);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 1, 0);
    send_item(OP_QUERY, 1023, 0, 0);
  endtask

  // zero node count: loads ignored, every query errors
  task automatic test_empty_tree();
    set_reg(CFG_NODE_COUNT, 0);
    send_item(OP_LOAD, 0, 0, 1);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 1023, 1023, 0);
  endtask

  // hand-built six node tree rooted at node 3
  task automatic test_small_tree();
    set_reg(CFG_NODE_COUNT, 6);
    set_reg(CFG_ROOT_NODE, 3);
    send_item(OP_LOAD, 3, 2, 1);
    send_item(OP_LOAD, 0, 3, 2);
    send_item(OP_LOAD, 1, 0, 3);
    send_item(OP_LOAD, 2, 0, 3);
    send_item(OP_LOAD, 4, 900, 2);
    send_item(OP_LOAD, 5, 1, 4);
    send_item(OP_QUERY, 1, 2, 0);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_QUERY, 1, 2, 0);
    send_item(OP_QUERY, 5, 2, 0);
    send_item(OP_QUERY, 2, 5, 0);
    send_item(OP_QUERY, 5, 4, 0);
    send_item(OP_QUERY, 3, 5, 0);
    send_item(OP_QUERY, 5, 5, 0);
    send_item(OP_QUERY, 1, 5, 0);
    // a load after the build leaves the table stale
    send_item(OP_LOAD, 2, 0, 3);
    send_item(OP_QUERY, 1, 2, 0);
    send_item(OP_BUILD, 0, 0, 0);
    send_item(OP_QUERY, 2, 4, 0);
  endtask

  task automatic test_random_trees();
    int cnt, root;
    for (int p = 0; p < 10; p++) begin
      cnt = (p == 7) ? $urandom_range(80, 140) : $urandom_range(2, 20);
      case (p % 3)
        0: root = 0;
        1: root = cnt - 1;
        default: root = $urandom_range(0, cnt - 1);
      endcase
      quiet = (p == 4);
      tree_phase(cnt, root, 1'b0, 14);
    end
    quiet = 1'b0;
  endtask

  task automatic test_scrambled_depths();
    tree_phase($urandom_range(8, 24), 0, 1'b1, 24);
    tree_phase($urandom_range(2, 16), 1, 1'b1, 24);
  endtask

  // a count past the table size keeps every node index in range
  task automatic test_count_cap();
    int cnt;
    cnt = $urandom_range(24, 48);
    tree_phase(cnt, cnt / 2, 1'b0, 24);
    set_reg(CFG_NODE_COUNT, 2047);
    set_reg(CFG_ROOT_NODE, 0);
    ask_queries(40, cnt);
  endtask

  initial begin
    for (int k = 0; k < LEVELS; k++) begin
      for (int v = 0; v < MAX_NODES; v++) lift_tab[k][v] = '0;
    end
    for (int v = 0; v < MAX_NODES; v++) depth_mem[v] = '0;
    tree_ready = 1'b0;
    cfg_count = 1;
    cfg_root = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_single_node();
    test_empty_tree();
    test_small_tree();
    test_random_trees();
    test_scrambled_depths();
    test_count_cap();

    drain_results();
    settle();
    if (lca_expect_q.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, lca_expect_q.size());
      mismatch_count++;
    end
    $display("covered %0d loads, %0d builds and %0d queries, node counts from 0 to past 1024",
             loads_sent, builds_sent, queries_sent);
    $display("checked %0d answers, %0d mismatches", answers_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[lowest_common_ancestor_binary_lifting] OK");
    end else begin
      $display("[lowest_common_ancestor_binary_lifting] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
